@@ design/dmsw_pkg.sv @@
// Shared types, constants and register codes for the depth map store.
`default_nettype none

package dmsw_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;

   localparam int CHAN_W        = 8;
   localparam int COORD_W       = 16;
   localparam int DEPTH_W       = 7;
   localparam int LEVEL_W       = 8;
   localparam int FRAME_SIZE_W  = 10;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 10;

   localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 10'd512;

   // mean of three channels: (sum * 683) >> 11 is exact for sums up to 2047
   localparam int MEAN3_MUL   = 683;
   localparam int MEAN3_SHIFT = 11;
   localparam int FULL_ALPHA  = 255;

   typedef enum logic [1:0] {
      FMT_GRAY       = 2'd0,
      FMT_GRAY_ALPHA = 2'd1,
      FMT_RGB        = 2'd2,
      FMT_RGB_ALPHA  = 2'd3
   } pix_fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIXEL_FORMAT  = 3'd0,
      CSR_FOCAL_BLEND   = 3'd1,
      CSR_FOCAL_LEVEL   = 3'd2,
      CSR_FRAME_WIDTH   = 3'd3,
      CSR_FRAME_HEIGHT  = 3'd4
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      logic                      cmd;
      logic [CHAN_W-1:0]         chan_0;
      logic [CHAN_W-1:0]         chan_1;
      logic [CHAN_W-1:0]         chan_2;
      logic [CHAN_W-1:0]         chan_3;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
   } dmsw_req_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]        depth_value;
      logic signed [LEVEL_W-1:0] focus_level;
   } dmsw_rsp_type;

endpackage

`default_nettype wire

@@ design/dmsw_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module dmsw_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [DATA_W-1:0]        wdata,
   output logic      [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/dmsw_conv.sv @@
// Four-stage pixel to depth conversion: mean, alpha blend, divide by 255, halve.
`default_nettype none

module dmsw_conv
   import dmsw_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire dmsw_req_type         req,
   input  wire pix_fmt_type          fmt,
   input  wire logic [CHAN_W-1:0]    blend,
   output logic                      out_valid,
   output logic [DEPTH_W-1:0]        depth
);

   logic              va_ff, vb_ff, vc_ff, vd_ff;
   logic [CHAN_W-1:0] mean_ff, c0_ff, alpha_ff;
   logic [CHAN_W-1:0] vb_val_ff, vc_val_ff;
   logic [15:0]       nb_ff, nc_ff;
   logic [CHAN_W-1:0] q0_ff;
   logic [DEPTH_W-1:0] depth_ff;

   logic [9:0]        sum;
   logic [20:0]       mean_prod;
   logic [CHAN_W-1:0] alpha_in, v_sel;
   logic [15:0]       n_in;
   logic [24:0]       n257;
   logic [16:0]       rem;
   logic [CHAN_W-1:0] q_fix, result;
   logic              use_mean, use_alpha;

   always_comb begin
      case (fmt)
         FMT_GRAY:       begin use_mean = 1'b0; use_alpha = 1'b0; end
         FMT_GRAY_ALPHA: begin use_mean = 1'b0; use_alpha = 1'b1; end
         FMT_RGB:        begin use_mean = 1'b1; use_alpha = 1'b0; end
         FMT_RGB_ALPHA:  begin use_mean = 1'b1; use_alpha = 1'b1; end
         default:        begin use_mean = 1'b0; use_alpha = 1'b0; end
      endcase
   end

   // stage A: channel mean by reciprocal multiply
   assign sum       = 10'(req.chan_0) + 10'(req.chan_1) + 10'(req.chan_2);
   assign mean_prod = 21'(sum) * 21'(MEAN3_MUL);
   assign alpha_in  = (fmt == FMT_GRAY_ALPHA) ? req.chan_1 : req.chan_3;

   // stage B: blend numerator v*a + f*(255-a)
   assign v_sel = use_mean ? mean_ff : c0_ff;
   assign n_in  = 16'(v_sel) * 16'(alpha_ff)
                + 16'(blend) * 16'(CHAN_W'(FULL_ALPHA) - alpha_ff);

   // stage C: quotient estimate n*257 >> 16, low by at most one
   assign n257 = (25'(nb_ff) << 8) + 25'(nb_ff);

   // stage D: one correction step
   assign rem    = 17'(nc_ff) - 17'(q0_ff) * 17'(FULL_ALPHA);
   assign q_fix  = (rem >= 17'(FULL_ALPHA)) ? q0_ff + 1'b1 : q0_ff;
   assign result = use_alpha ? q_fix : vc_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      mean_ff   <= mean_prod[MEAN3_SHIFT +: CHAN_W];
      c0_ff     <= req.chan_0;
      alpha_ff  <= alpha_in;
      vb_val_ff <= v_sel;
      nb_ff     <= n_in;
      vc_val_ff <= vb_val_ff;
      nc_ff     <= nb_ff;
      q0_ff     <= n257[23:16];
      depth_ff  <= result[CHAN_W-1:1];
   end

   assign out_valid = vd_ff;
   assign depth     = depth_ff;

endmodule

`default_nettype wire

@@ design/dmsw_wrap.sv @@
// Floor modulo of a signed coordinate by the frame size, one quotient bit per cycle.
`default_nettype none

module dmsw_wrap
   import dmsw_pkg::*;
#(
   parameter int MAX_N = DEF_MAX_WIDTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic signed [COORD_W-1:0]   raw,
   input  wire logic [$clog2(MAX_N+1)-1:0]  n,
   output logic                             done,
   output logic [$clog2(MAX_N)-1:0]         result
);

   localparam int N_W   = $clog2(MAX_N + 1);
   localparam int R_W   = $clog2(MAX_N);
   localparam int CNT_W = $clog2(COORD_W);

   logic               run_ff, done_ff, neg_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COORD_W-1:0] mag_ff;
   logic [N_W-1:0]     rem_ff, n_ff;

   logic [COORD_W-1:0] raw_u, mag_in;
   logic [N_W:0]       trial;
   logic [N_W-1:0]     rem_step, fixed;

   assign raw_u  = raw;
   assign mag_in = raw_u[COORD_W-1] ? COORD_W'(~raw_u + 1'b1) : raw_u;

   assign trial    = {rem_ff, mag_ff[COORD_W-1]};
   assign rem_step = (trial >= {1'b0, n_ff}) ? N_W'(trial - {1'b0, n_ff}) : N_W'(trial);

   // negative input: remainder of the magnitude folds back from n
   assign fixed = (neg_ff && (rem_ff != '0)) ? n_ff - rem_ff : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         mag_ff <= mag_in;
         rem_ff <= '0;
         n_ff   <= n;
         neg_ff <= raw_u[COORD_W-1];
      end else if (run_ff) begin
         mag_ff <= {mag_ff[COORD_W-2:0], 1'b0};
         rem_ff <= rem_step;
      end
   end

   assign done   = done_ff;
   assign result = R_W'(fixed);

endmodule

`default_nettype wire

@@ design/depth_map_store_wrapped_lookup_unit.sv @@
// Top level: registers, sequencer and depth store for the wrapped depth lookup.
//
//   port group   direction  handshake                       payload
//   req_*        in         start / busy                    dmsw_req_type req_item
//   rsp_*        out        rsp_strobe, one cycle, no stall dmsw_rsp_type rsp_item
//   csr_*        in         csr_valid / csr_ready           csr_index, csr_data
//
// A load passes through the four conversion stages and the store write before the next
// accept is possible. A query runs the 16-step remainder units for x and y, then
// multiply, add, store read and output register. Synchronous reset clears the
// configuration registers, the write index and the sequencer; the store holds no
// reset value. busy is high while an item is in work; the result strobe is high in
// the first cycle with busy low again. csr_ready is low while busy.
`default_nettype none

module depth_map_store_wrapped_lookup_unit
   import dmsw_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire dmsw_req_type          req_item,
   output logic                       rsp_strobe,
   output dmsw_rsp_type               rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int WN_W        = $clog2(MAX_WIDTH + 1);
   localparam int HN_W        = $clog2(MAX_HEIGHT + 1);
   localparam int XR_W        = $clog2(MAX_WIDTH);
   localparam int YR_W        = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int SZ_W        = IDX_W + 1;
   localparam int SZP_W       = WN_W + HN_W;
   localparam int PRD_W       = YR_W + WN_W;
   localparam int WC_W        = (FRAME_SIZE_W > WN_W) ? FRAME_SIZE_W : WN_W;
   localparam int HC_W        = (FRAME_SIZE_W > HN_W) ? FRAME_SIZE_W : HN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_WRAP,
      S_MUL,
      S_ADD,
      S_READ,
      S_OUT
   } state_type;

   // configuration registers
   pix_fmt_type             pixel_format_ff;
   logic [CHAN_W-1:0]       focal_blend_ff;
   logic [DEPTH_W-1:0]      focal_level_ff;
   logic [FRAME_SIZE_W-1:0] frame_width_ff, frame_height_ff;

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   dmsw_rsp_type       rsp_item_ff, rsp_item_in;
   logic [IDX_W-1:0]   widx_ff, widx_in;
   logic [SZ_W-1:0]    size_ff;
   logic [XR_W-1:0]    x_ff, x_in;
   logic [YR_W-1:0]    y_ff, y_in;
   logic [PRD_W-1:0]   prod_ff, prod_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;

   logic [WN_W-1:0]    eff_w;
   logic [HN_W-1:0]    eff_h;
   logic [WC_W-1:0]    wide_w;
   logic [HC_W-1:0]    wide_h;
   logic               accept, conv_valid, wrap_x_done, wrap_y_done;
   logic [DEPTH_W-1:0] conv_depth, ram_rdata;
   logic [XR_W-1:0]    wrap_x;
   logic [YR_W-1:0]    wrap_y;
   logic [IDX_W-1:0]   wcur, ram_addr;
   logic [SZ_W-1:0]    wnext;
   logic               ram_we;
   logic [LEVEL_W-1:0] level;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_GRAY;
         focal_blend_ff  <= '0;
         focal_level_ff  <= '0;
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= pix_fmt_type'(csr_data[1:0]);
            CSR_FOCAL_BLEND:  focal_blend_ff  <= csr_data[CHAN_W-1:0];
            CSR_FOCAL_LEVEL:  focal_level_ff  <= csr_data[DEPTH_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FRAME_SIZE_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FRAME_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame size: zero acts as one, clamp at the store limits
   assign wide_w = WC_W'(frame_width_ff);
   assign wide_h = HC_W'(frame_height_ff);

   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WN_W'(1);
      end else if (wide_w > WC_W'(MAX_WIDTH)) begin
         eff_w = WN_W'(MAX_WIDTH);
      end else begin
         eff_w = WN_W'(wide_w);
      end
      if (frame_height_ff == '0) begin
         eff_h = HN_W'(1);
      end else if (wide_h > HC_W'(MAX_HEIGHT)) begin
         eff_h = HN_W'(MAX_HEIGHT);
      end else begin
         eff_h = HN_W'(wide_h);
      end
   end

   dmsw_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && (req_item.cmd == CMD_LOAD)),
      .req       (req_item),
      .fmt       (pixel_format_ff),
      .blend     (focal_blend_ff),
      .out_valid (conv_valid),
      .depth     (conv_depth)
   );

   dmsw_wrap #(.MAX_N(MAX_WIDTH)) u_wrap_x (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_item.cmd == CMD_QUERY)),
      .raw    (req_item.query_x),
      .n      (eff_w),
      .done   (wrap_x_done),
      .result (wrap_x)
   );

   dmsw_wrap #(.MAX_N(MAX_HEIGHT)) u_wrap_y (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_item.cmd == CMD_QUERY)),
      .raw    (req_item.query_y),
      .n      (eff_h),
      .done   (wrap_y_done),
      .result (wrap_y)
   );

   // write index restarts when the frame shrank below it
   assign wcur  = (SZ_W'(widx_ff) >= size_ff) ? '0 : widx_ff;
   assign wnext = SZ_W'(wcur) + 1'b1;

   // loads write and queries read through the one port; items never overlap
   assign ram_we   = (state_ff == S_LOAD) && conv_valid;
   assign ram_addr = (state_ff == S_LOAD) ? wcur : addr_ff;

   dmsw_ram #(.DATA_W(DEPTH_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (conv_depth),
      .rdata (ram_rdata)
   );

   assign level = {1'b0, ram_rdata} - {1'b0, focal_level_ff};

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      widx_in       = widx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      prod_in       = PRD_W'(y_ff) * PRD_W'(eff_w);
      addr_in       = IDX_W'(prod_ff + PRD_W'(x_ff));
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_item.cmd == CMD_QUERY) ? S_WRAP : S_LOAD;
            end
         end
         S_LOAD: begin
            if (conv_valid) begin
               widx_in  = (wnext >= size_ff) ? '0 : IDX_W'(wnext);
               state_in = S_IDLE;
            end
         end
         S_WRAP: begin
            if (wrap_x_done && wrap_y_done) begin
               x_in     = wrap_x;
               y_in     = wrap_y;
               state_in = S_MUL;
            end
         end
         S_MUL:  state_in = S_ADD;
         S_ADD:  state_in = S_READ;
         S_READ: state_in = S_OUT;
         S_OUT: begin
            rsp_strobe_in           = 1'b1;
            rsp_item_in.depth_value = ram_rdata;
            rsp_item_in.focus_level = $signed(level);
            state_in                = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         widx_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         widx_ff       <= widx_in;
      end
      rsp_item_ff <= rsp_item_in;
      size_ff     <= SZ_W'(SZP_W'(eff_w) * SZP_W'(eff_h));
      x_ff        <= x_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      addr_ff     <= addr_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ((WN_W'(x_ff) < eff_w) && (HN_W'(y_ff) < eff_h)))
      else $error("wrapped coordinate outside the frame");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (SZ_W'(wcur) < size_ff))
      else $error("store write beyond the frame size");

endmodule

`default_nettype wire

@@ tb/sv/depth_map_store_wrapped_lookup_unit_tb.sv @@
// Self-checking testbench for the depth map store with wrapped lookup.
`timescale 1ns / 1ps

module depth_map_store_wrapped_lookup_unit_tb;
   import dmsw_pkg::*;

   localparam int MAX_W          = DEF_MAX_WIDTH;
   localparam int MAX_H          = DEF_MAX_HEIGHT;
   localparam int STORE_CELLS    = MAX_W * MAX_H;
   localparam int CELL_W         = $clog2(STORE_CELLS);
   localparam int REQ_W          = $bits(dmsw_req_type);
   localparam int RGB_CHANNELS   = 3;
   localparam int NUM_PHASES     = 11;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int TAIL_CYCLES    = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_IDX_W'(CSR_FRAME_HEIGHT + 1);

   typedef enum bit {ROW_CONFIG, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      dmsw_req_type          item;
      bit                    typed;
      dmsw_rsp_type          want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   dmsw_req_type          req_item = '0;
   logic                  rsp_strobe;
   dmsw_rsp_type          rsp_item;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   depth_map_store_wrapped_lookup_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mirror of the block's registers and store
   pix_fmt_type              cfg_fmt    = FMT_GRAY;
   logic [CHAN_W-1:0]        cfg_blend  = '0;
   logic [DEPTH_W-1:0]       cfg_level  = '0;
   logic [FRAME_SIZE_W-1:0]  cfg_width  = FRAME_SIZE_RESET;
   logic [FRAME_SIZE_W-1:0]  cfg_height = FRAME_SIZE_RESET;
   logic [DEPTH_W-1:0]       depth_mirror [0:STORE_CELLS-1];
   bit                       written_map [0:STORE_CELLS-1];
   int                       written_addrs [$];
   int                       wr_ptr = 0;

   dmsw_rsp_type expected_lookups [$];
   stim_row_type stim_rows [$];
   int err_count = 0;
   int loads_sent = 0;
   int lookups_checked = 0;
   int cfg_writes = 0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic int eff_dim(input logic [FRAME_SIZE_W-1:0] v, input int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic logic [DEPTH_W-1:0] to_depth(input dmsw_req_type r);
      int c0, c1, c2, c3, f, v;
      c0 = int'(r.chan_0);
      c1 = int'(r.chan_1);
      c2 = int'(r.chan_2);
      c3 = int'(r.chan_3);
      f = int'(cfg_blend);
      case (cfg_fmt)
         FMT_GRAY:       v = c0;
         FMT_GRAY_ALPHA: v = (c0 * c1 + f * (FULL_ALPHA - c1)) / FULL_ALPHA;
         FMT_RGB:        v = (c0 + c1 + c2) / RGB_CHANNELS;
         default: v = ((c0 + c1 + c2) / RGB_CHANNELS * c3 + f * (FULL_ALPHA - c3))
                      / FULL_ALPHA;
      endcase
      return DEPTH_W'(v / 2);
   endfunction

   task automatic apply_config(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_PIXEL_FORMAT: cfg_fmt    = pix_fmt_type'(val[1:0]);
         CSR_FOCAL_BLEND:  cfg_blend  = val[CHAN_W-1:0];
         CSR_FOCAL_LEVEL:  cfg_level  = val[DEPTH_W-1:0];
         CSR_FRAME_WIDTH:  cfg_width  = val;
         CSR_FRAME_HEIGHT: cfg_height = val;
         default: ;
      endcase
   endtask

   task automatic apply_item(input dmsw_req_type r, output bit has_rsp,
                             output dmsw_rsp_type rsp);
      int w, h, cells, qx, qy, addr;
      logic [DEPTH_W-1:0] d;
      w = eff_dim(cfg_width, MAX_W);
      h = eff_dim(cfg_height, MAX_H);
      cells = w * h;
      has_rsp = 1'b0;
      rsp = '0;
      if (r.cmd == CMD_LOAD) begin
         if (wr_ptr >= cells) wr_ptr = 0;
         depth_mirror[CELL_W'(wr_ptr)] = to_depth(r);
         if (!written_map[CELL_W'(wr_ptr)]) begin
            written_map[CELL_W'(wr_ptr)] = 1'b1;
            written_addrs.push_back(wr_ptr);
         end
         wr_ptr++;
         if (wr_ptr >= cells) wr_ptr = 0;
      end else begin
         // floor modulo: exact negative multiples land on 0
         qx = $signed(r.query_x) % w;
         if (qx < 0) qx += w;
         qy = $signed(r.query_y) % h;
         if (qy < 0) qy += h;
         addr = qy * w + qx;
         d = depth_mirror[CELL_W'(addr)];
         rsp.depth_value = d;
         rsp.focus_level = {1'b0, d} - {1'b0, cfg_level};
         has_rsp = 1'b1;
      end
   endtask

   function automatic int rand_chan();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 255;
         default: return int'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic dmsw_req_type mk_load(input int c0, input int c1, input int c2,
                                            input int c3);
      dmsw_req_type it;
      it.cmd = CMD_LOAD;
      it.chan_0 = CHAN_W'(c0);
      it.chan_1 = CHAN_W'(c1);
      it.chan_2 = CHAN_W'(c2);
      it.chan_3 = CHAN_W'(c3);
      it.query_x = COORD_W'($urandom);
      it.query_y = COORD_W'($urandom);
      return it;
   endfunction

   function automatic dmsw_req_type mk_query(input int x, input int y);
      dmsw_req_type it;
      it = dmsw_req_type'(REQ_W'({$urandom, $urandom, $urandom}));
      it.cmd = CMD_QUERY;
      it.query_x = COORD_W'(x);
      it.query_y = COORD_W'(y);
      return it;
   endfunction

   // any 16-bit signed value that folds onto target modulo n
   function automatic int spread_coord(input int target, input int n);
      int kmin, kmax, k;
      kmin = -((32768 + target) / n);
      kmax = (32767 - target) / n;
      case ($urandom_range(0, 7))
         0: k = kmin;
         1: k = kmax;
         default: k = kmin + int'($urandom_range(kmax - kmin, 0));
      endcase
      return target + k * n;
   endfunction

   // written address inside the current frame, or -1
   function automatic int pick_written(input int cells);
      int a;
      if (written_addrs.size() == 0) return -1;
      for (int i = 0; i < 32; i++) begin
         a = written_addrs[$urandom_range(written_addrs.size() - 1, 0)];
         if (a < cells) return a;
      end
      return written_map[0] ? 0 : -1;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row = '{ROW_CONFIG, idx, val, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type load_row(input int c0, input int c1, input int c2,
                                             input int c3);
      stim_row_type row;
      row = '{ROW_ITEM, '0, '0, mk_load(c0, c1, c2, c3), 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type query_row(input int x, input int y);
      stim_row_type row;
      row = '{ROW_ITEM, '0, '0, mk_query(x, y), 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type checked_row(input int x, input int y, input int d,
                                                input int lvl);
      stim_row_type row;
      dmsw_rsp_type want;
      want.depth_value = DEPTH_W'(d);
      want.focus_level = LEVEL_W'(lvl);
      row = '{ROW_ITEM, '0, '0, mk_query(x, y), 1'b1, want};
      return row;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_config(idx, val);
      cfg_writes++;
   endtask

   // leaves start high; the caller lowers it or sends the next item
   task automatic send_item(input dmsw_req_type it, input bit typed,
                            input dmsw_rsp_type want);
      bit has_rsp;
      dmsw_rsp_type rsp;
      req_item <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      apply_item(it, has_rsp, rsp);
      if (has_rsp) expected_lookups.push_back(typed ? want : rsp);
      else loads_sent++;
   endtask

   task automatic settle();
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      dmsw_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected result depth %0d level %0d",
                                      rsp_item.depth_value, rsp_item.focus_level));
         end else begin
            want = expected_lookups.pop_front();
            lookups_checked++;
            if (rsp_item.depth_value !== want.depth_value)
               report_mismatch($sformatf("depth_value got %0d want %0d",
                                         rsp_item.depth_value, want.depth_value));
            if (rsp_item.focus_level !== want.focus_level)
               report_mismatch($sformatf("focus_level got %0d want %0d",
                                         rsp_item.focus_level, want.focus_level));
         end
      end
   end

   initial begin
      #3_000_000;
      $display("timeout: block stopped answering");
      $display("depth_map_store_wrapped_lookup_unit_tb failed");
      $finish;
   end

   initial begin
      bit in_cfg;
      int w, h, addr, idle_rate;
      int fmt, blend, lvl, wd, ht;
      dmsw_req_type it;

      // directed: reset defaults, value extremes, every format, wrap corner cases
      stim_rows.push_back(load_row(0, 255, 255, 255));
      stim_rows.push_back(load_row(255, 0, 0, 0));
      stim_rows.push_back(checked_row(0, 0, 0, 0));
      stim_rows.push_back(checked_row(1, 0, 127, 127));
      stim_rows.push_back(checked_row(-512, 0, 0, 0));
      stim_rows.push_back(checked_row(-32768, -32768, 0, 0));
      stim_rows.push_back(checked_row(-511, -512, 127, 127));
      stim_rows.push_back(cfg_row(CSR_FOCAL_LEVEL, 127));
      stim_rows.push_back(checked_row(1, 0, 127, 0));
      stim_rows.push_back(checked_row(0, 0, 0, -127));
      stim_rows.push_back(cfg_row(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_GRAY_ALPHA)));
      stim_rows.push_back(cfg_row(CSR_FOCAL_BLEND, 255));
      stim_rows.push_back(load_row(0, 0, 255, 255));
      stim_rows.push_back(load_row(0, 255, 0, 0));
      stim_rows.push_back(checked_row(2, 0, 127, 0));
      stim_rows.push_back(checked_row(3, 0, 0, -127));
      stim_rows.push_back(cfg_row(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_RGB)));
      stim_rows.push_back(load_row(255, 255, 255, 0));
      stim_rows.push_back(load_row(1, 1, 0, 255));
      stim_rows.push_back(cfg_row(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_RGB_ALPHA)));
      stim_rows.push_back(cfg_row(CSR_FOCAL_BLEND, 0));
      stim_rows.push_back(cfg_row(CSR_FOCAL_LEVEL, 0));
      stim_rows.push_back(load_row(255, 255, 255, 0));
      stim_rows.push_back(load_row(255, 255, 254, 255));
      stim_rows.push_back(query_row(4, 0));
      stim_rows.push_back(query_row(7, 0));
      // shrink the frame mid-stream: write index is past the end and restarts
      stim_rows.push_back(cfg_row(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_GRAY)));
      stim_rows.push_back(cfg_row(CSR_FRAME_WIDTH, 3));
      stim_rows.push_back(cfg_row(CSR_FRAME_HEIGHT, 2));
      stim_rows.push_back(load_row(100, 0, 0, 0));
      stim_rows.push_back(query_row(32767, 32767));
      stim_rows.push_back(query_row(-3, -2));
      // zero and oversize frame dimensions, writes to unused register slots
      stim_rows.push_back(cfg_row(CSR_FRAME_WIDTH, 0));
      stim_rows.push_back(cfg_row(CSR_FRAME_HEIGHT, 1023));
      stim_rows.push_back(cfg_row(CSR_SPARE_FIRST, 1023));
      stim_rows.push_back(cfg_row(CSR_IDX_W'(CSR_SPARE_FIRST + 2), 0));
      stim_rows.push_back(load_row(2, 0, 0, 0));
      stim_rows.push_back(query_row(5, 1));
      stim_rows.push_back(cfg_row(CSR_FRAME_WIDTH, 1023));
      stim_rows.push_back(cfg_row(CSR_FRAME_HEIGHT, 0));
      stim_rows.push_back(query_row(-512, 7));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      in_cfg = 1'b0;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CONFIG) begin
            if (!in_cfg) begin
               start <= 1'b0;
               settle();
            end
            write_reg(stim_rows[i].csr_idx, stim_rows[i].csr_val);
            in_cfg = 1'b1;
         end else begin
            if (in_cfg) csr_valid <= 1'b0;
            in_cfg = 1'b0;
            send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         start <= 1'b0;
         settle();
         fmt   = (phase < 8) ? phase % 4 : $urandom_range(0, 3);
         blend = (phase == 0) ? 0 : (phase == 1) ? 255 : $urandom_range(0, 255);
         lvl   = (phase == 0) ? 0 : (phase == 1) ? 127 : $urandom_range(0, 127);
         case (phase)
            0: begin wd = 1;    ht = 1;    end
            1: begin wd = 512;  ht = 512;  end
            2: begin wd = 1023; ht = 0;    end
            3: begin wd = 0;    ht = 1023; end
            default: begin
               if (phase % 3 == 0) begin
                  wd = $urandom_range(0, 1023);
                  ht = $urandom_range(0, 1023);
               end else begin
                  wd = $urandom_range(1, 12);
                  ht = $urandom_range(1, 12);
               end
            end
         endcase
         // bits above each register's width ride along and must be dropped
         write_reg(CSR_PIXEL_FORMAT, CSR_DATA_W'(($urandom & 10'h3FC) | fmt));
         write_reg(CSR_FOCAL_BLEND, CSR_DATA_W'(($urandom & 10'h300) | blend));
         write_reg(CSR_FOCAL_LEVEL, CSR_DATA_W'(($urandom & 10'h380) | lvl));
         write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(wd));
         write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(ht));
         if ($urandom_range(0, 1))
            write_reg(CSR_IDX_W'(CSR_SPARE_FIRST + $urandom_range(0, 2)),
                      CSR_DATA_W'($urandom));
         csr_valid <= 1'b0;

         idle_rate = (phase >= NUM_PHASES - 2) ? 0 : $urandom_range(0, 3);
         w = eff_dim(cfg_width, MAX_W);
         h = eff_dim(cfg_height, MAX_H);
         repeat (ITEMS_PER_PHASE) begin
            if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
               start    <= 1'b0;
               req_item <= dmsw_req_type'(REQ_W'({$urandom, $urandom, $urandom}));
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end
            addr = $urandom_range(0, 1) ? pick_written(w * h) : -1;
            if (addr >= 0)
               it = mk_query(spread_coord(addr % w, w), spread_coord(addr / w, h));
            else
               it = mk_load(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            send_item(it, 1'b0, '0);
         end
      end

      start <= 1'b0;
      settle();
      $display("covered %0d pixel loads and %0d depth lookups checked", loads_sent,
               lookups_checked);
      $display("across %0d register writes, all formats and frame sizes 1..oversize",
               cfg_writes);
      if (err_count == 0) begin
         $display("depth_map_store_wrapped_lookup_unit_tb passed");
      end else begin
         $display("depth_map_store_wrapped_lookup_unit_tb failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dmsw_pkg.sv
design/dmsw_ram.sv
design/dmsw_conv.sv
design/dmsw_wrap.sv
design/depth_map_store_wrapped_lookup_unit.sv
tb/sv/depth_map_store_wrapped_lookup_unit_tb.sv
